FILE: rtl/wlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wlr_pkg;

    // Row geometry and field widths.
    localparam int MAX_HALF_LENGTH = 1024;
    localparam int HALF_W          = 11;
    localparam int SAMPLE_W        = 16;
    localparam int INDEX_W         = 10;
    localparam int EVEN_TAPS       = 3;
    localparam int ODD_TAPS        = 2;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_HALF  = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;
    localparam logic [1:0] REG_GATE  = 2'd3;

    // Wavelet mode register codes.
    localparam logic [1:0] MODE_HAAR     = 2'd0;
    localparam logic [1:0] MODE_CDF53    = 2'd1;
    localparam logic [1:0] MODE_FOUR_TAP = 2'd2;

    // Position of a coefficient pair relative to the newest pair j.
    localparam logic [1:0] SLOT_LOW  = 2'd0;  // pair j-2
    localparam logic [1:0] SLOT_MID  = 2'd1;  // pair j-1
    localparam logic [1:0] SLOT_HIGH = 2'd2;  // pair j

    // Predict filter actually applied to a coefficient pair.
    typedef enum logic [1:0] {
        LIFT_HAAR,
        LIFT_CDF53,
        LIFT_FOUR_TAP
    } lift_kind_t;

    typedef struct packed {
        logic [1:0]  wavelet_mode;
        logic [10:0] half_length;
        logic [15:0] level_limit;
        logic [19:0] gate_threshold;
    } wlr_cfg_t;

    // One coefficient pair with its edge-resolved operands and partial sums.
    typedef struct packed {
        lift_kind_t                  kind;
        logic [INDEX_W-1:0]          index;
        logic signed [SAMPLE_W-1:0]  cur;
        logic signed [SAMPLE_W-1:0]  odd;
        logic signed [SAMPLE_W:0]    sum_a;
        logic signed [SAMPLE_W:0]    s9;
        logic signed [SAMPLE_W:0]    s1;
        logic                        i_zero;
        logic                        row_done;
        logic                        run_last;
    } wlr_slot_t;

    // Half length clamped to the supported range.
    function automatic logic [HALF_W-1:0] clamp_len(input logic [HALF_W-1:0] hl);
        logic [HALF_W-1:0] n;
        n = hl;
        if (hl < HALF_W'(2))
            n = HALF_W'(2);
        else if (hl > HALF_W'(MAX_HALF_LENGTH))
            n = HALF_W'(MAX_HALF_LENGTH);
        return n;
    endfunction

    // The four-tap predict needs more than four pairs, else 5/3 is used.
    function automatic lift_kind_t lift_kind_of(input logic [1:0] mode,
                                                input logic [HALF_W-1:0] n);
        lift_kind_t k;
        k = LIFT_CDF53;
        if (mode == MODE_HAAR)
            k = LIFT_HAAR;
        else if (mode == MODE_FOUR_TAP && n > HALF_W'(4))
            k = LIFT_FOUR_TAP;
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/wlr_pair_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wlr_pair_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] even_sample;
    logic signed [15:0] odd_sample;

    modport source (output valid, output even_sample, output odd_sample, input ready);
    modport sink (input valid, input even_sample, input odd_sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/wlr_coef_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wlr_coef_if;
    logic               valid;
    logic               ready;
    logic [9:0]         coefficient_index;
    logic signed [15:0] lowpass;
    logic signed [15:0] highpass;
    logic               row_done;
    logic               run_last;

    modport source (
        output valid, output coefficient_index, output lowpass, output highpass,
        output row_done, output run_last, input ready
    );
    modport sink (
        input valid, input coefficient_index, input lowpass, input highpass,
        input row_done, input run_last, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/wlr_sample_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module wlr_sample_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                shift_en,
    input  logic signed [wlr_pkg::SAMPLE_W-1:0] sample_in,
    output logic signed [wlr_pkg::SAMPLE_W-1:0] sample_out
);
    import wlr_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;

    // Take the neighbor's sample whenever the window moves.
    always_comb
    begin
        sample_next = sample_reg;
        if (shift_en)
            sample_next = sample_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_reg <= '0;
        else
            sample_reg <= sample_next;
    end

    assign sample_out = sample_reg;

endmodule

`default_nettype wire

FILE: rtl/wlr_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module wlr_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wlr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wlr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wlr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output wlr_pkg::wlr_cfg_t               cfg
);
    import wlr_pkg::*;

    wlr_cfg_t   cfg_reg;
    wlr_cfg_t   cfg_next;
    logic       write_en;
    logic [1:0] reg_sel;

    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite;
    assign reg_sel  = paddr[APB_ADDR_W-1:2];

    // Register write decode; each field keeps only its own width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (reg_sel)
                REG_MODE:  cfg_next.wavelet_mode   = pwdata[1:0];
                REG_HALF:  cfg_next.half_length    = pwdata[10:0];
                REG_LIMIT: cfg_next.level_limit    = pwdata[15:0];
                REG_GATE:  cfg_next.gate_threshold = pwdata[19:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wavelet_mode   <= MODE_CDF53;
            cfg_reg.half_length    <= 11'd2;
            cfg_reg.level_limit    <= '0;
            cfg_reg.gate_threshold <= '0;
        end
        else
            cfg_reg <= cfg_next;
    end

    // Read-back mux.
    always_comb
    begin
        unique case (reg_sel)
            REG_MODE:  prdata = {30'd0, cfg_reg.wavelet_mode};
            REG_HALF:  prdata = {21'd0, cfg_reg.half_length};
            REG_LIMIT: prdata = {16'd0, cfg_reg.level_limit};
            REG_GATE:  prdata = {12'd0, cfg_reg.gate_threshold};
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/wlr_lift_core.sv
`timescale 1ns / 1ps
`default_nettype none

module wlr_lift_core (
    input  logic                clk,
    input  logic                rst_n,
    input  wlr_pkg::wlr_cfg_t   cfg,
    input  logic                slot_valid,
    input  wlr_pkg::wlr_slot_t  slot,
    output logic                slot_ready,
    wlr_coef_if.source          coefs
);
    import wlr_pkg::*;

    typedef struct packed {
        logic [INDEX_W-1:0]         index;
        logic signed [SAMPLE_W-1:0] cur;
        logic signed [SAMPLE_W-1:0] hp;
        logic signed [SAMPLE_W-1:0] haar_lp;
        logic                       is_haar;
        logic                       i_zero;
        logic                       row_done;
        logic                       run_last;
    } wlr_hp_t;

    typedef struct packed {
        logic [INDEX_W-1:0]         index;
        logic signed [SAMPLE_W-1:0] lowpass;
        logic signed [SAMPLE_W-1:0] highpass;
        logic                       row_done;
        logic                       run_last;
    } wlr_out_t;

    logic      a_valid_reg, a_valid_next;
    logic      b_valid_reg, b_valid_next;
    logic      out_valid_reg, out_valid_next;
    wlr_slot_t a_reg;
    wlr_hp_t   b_reg, b_next;
    wlr_out_t  out_reg, out_next;
    logic signed [SAMPLE_W-1:0] prev_hp_reg, prev_hp_next;

    logic out_adv, b_free, a_free;

    logic signed [21:0]         four_sum;
    logic signed [SAMPLE_W:0]   sum_half;
    logic signed [17:0]         pred;
    logic signed [18:0]         hp_wide;

    logic [HALF_W-1:0]          n_len;
    logic signed [SAMPLE_W-1:0] prev_hp;
    logic signed [17:0]         upd;
    logic signed [SAMPLE_W:0]   lp_wide;
    logic signed [21:0]         scaled;
    logic signed [21:0]         gate_g;
    logic                       lim_clear;
    logic                       dead_zone;

    // Stage moves: a stage takes new data when it is empty or drains.
    assign out_adv    = !out_valid_reg || coefs.ready;
    assign b_free     = !b_valid_reg || out_adv;
    assign a_free     = !a_valid_reg || b_free;
    assign slot_ready = a_free;

    // Predict stage: highpass before gating.
    always_comb
    begin
        four_sum = (22'(a_reg.s9) <<< 3) + 22'(a_reg.s9) - 22'(a_reg.s1) + 22'sd8;
        sum_half = a_reg.sum_a >>> 1;
        if (a_reg.kind == LIFT_FOUR_TAP)
            pred = 18'(four_sum >>> 4);
        else
            pred = 18'(sum_half);
        hp_wide = 19'(a_reg.odd) - 19'(pred);

        b_next.index    = a_reg.index;
        b_next.cur      = a_reg.cur;
        b_next.hp       = hp_wide[SAMPLE_W-1:0];
        b_next.haar_lp  = sum_half[SAMPLE_W-1:0];
        b_next.is_haar  = (a_reg.kind == LIFT_HAAR);
        b_next.i_zero   = a_reg.i_zero;
        b_next.row_done = a_reg.row_done;
        b_next.run_last = a_reg.run_last;
    end

    // Update stage plus level limit and dead-zone gate.
    always_comb
    begin
        n_len     = clamp_len(cfg.half_length);
        prev_hp   = b_reg.i_zero ? b_reg.hp : prev_hp_reg;
        upd       = (18'(b_reg.hp) + 18'(prev_hp) + 18'sd2) >>> 2;
        lp_wide   = 17'(b_reg.cur) + 17'(upd);
        lim_clear = (cfg.level_limit != 16'd0)
                    && ({4'd0, n_len, 1'b0} > cfg.level_limit);
        scaled    = {{2{b_reg.hp[SAMPLE_W-1]}}, b_reg.hp, 4'd0};
        gate_g    = {2'd0, cfg.gate_threshold};
        dead_zone = (scaled > -gate_g) && (scaled < gate_g);

        out_next.index    = b_reg.index;
        out_next.lowpass  = b_reg.is_haar ? b_reg.haar_lp : lp_wide[SAMPLE_W-1:0];
        out_next.highpass = (lim_clear || dead_zone) ? '0 : b_reg.hp;
        out_next.row_done = b_reg.row_done;
        out_next.run_last = b_reg.run_last;
    end

    // Valid flags and the running highpass history.
    always_comb
    begin
        a_valid_next   = a_valid_reg;
        b_valid_next   = b_valid_reg;
        out_valid_next = out_valid_reg;
        prev_hp_next   = prev_hp_reg;
        if (a_free)
            a_valid_next = slot_valid;
        if (b_free)
            b_valid_next = a_valid_reg;
        if (out_adv)
            out_valid_next = b_valid_reg;
        if (out_adv && b_valid_reg)
            prev_hp_next = b_reg.hp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_hp_reg   <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            prev_hp_reg   <= prev_hp_next;
        end
    end

    // Payload stages load only with valid data moving in.
    always_ff @(posedge clk)
    begin
        if (a_free && slot_valid)
            a_reg <= slot;
        if (b_free && a_valid_reg)
            b_reg <= b_next;
        if (out_adv && b_valid_reg)
            out_reg <= out_next;
    end

    assign coefs.valid             = out_valid_reg;
    assign coefs.coefficient_index = out_reg.index;
    assign coefs.lowpass           = out_reg.lowpass;
    assign coefs.highpass          = out_reg.highpass;
    assign coefs.row_done          = out_reg.row_done;
    assign coefs.run_last          = out_reg.run_last;

`ifndef NO_ASSERTIONS
    // The row's final pair always closes the run of its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.row_done |-> out_reg.run_last)
        else $error("row_done without run_last");

    // Highpass history moves only when a pair enters the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_adv && b_valid_reg) |=> $stable(prev_hp_reg))
        else $error("highpass history changed without an output load");

    // A waiting coefficient transaction keeps its payload until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        coefs.valid && !coefs.ready |=> coefs.valid && $stable(out_reg))
        else $error("coefficient transaction changed while waiting");
`endif

endmodule

`default_nettype wire

FILE: rtl/wavelet_lift_row_gate.sv
// Integer lifting wavelet for one row (Haar, CDF 5/3 or four-tap with 5/3 fallback),
// with level limit and dead-zone gate on the highpass. Sample pairs enter one per
// cycle while the issue register is free or handing on its last pair; the coefficient
// pair two positions back leaves through the issue register, the predict and update
// stages and a registered output. A row's last pair also flushes the two newest
// positions, so that transaction yields three results (two when the row has two
// pairs) and holds input off until the issue register has handed them all on. The
// issue register hands one coefficient pair per cycle, while the pipeline can take
// it, to the predict and update pipeline. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module wavelet_lift_row_gate (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wlr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wlr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wlr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    wlr_pair_if.sink                        samples,
    wlr_coef_if.source                      coefs
);
    import wlr_pkg::*;

    wlr_cfg_t          cfg;
    logic [HALF_W-1:0] n_len;

    // Sample window: element 0 is the incoming pair, higher is older.
    logic signed [SAMPLE_W-1:0] even_chain [0:EVEN_TAPS];
    logic signed [SAMPLE_W-1:0] odd_chain  [0:ODD_TAPS];

    logic [HALF_W-1:0] count_reg, count_next;
    logic              in_fire, is_last, has_job;

    // Issue register: snapshot of one transaction's pending coefficient pairs.
    logic              job_valid_reg, job_valid_next;
    logic [1:0]        slot_reg, slot_next;
    logic [1:0]        end_slot_reg, end_slot_next;
    logic              job_last_reg, job_last_next;
    logic [HALF_W-1:0] job_j_reg;
    logic signed [SAMPLE_W-1:0] job_even_reg [0:3];
    logic signed [SAMPLE_W-1:0] job_odd_reg  [0:2];

    logic              slot_ready, slot_fire, job_done;
    wlr_slot_t         slot;

    logic signed [SAMPLE_W-1:0] cur, odd, em1, ep1, ep2;
    logic signed [SAMPLE_W-1:0] nxt, il1, ip1, ip2;
    logic [HALF_W-1:0]          i_pos;
    logic [HALF_W:0]            i_plus2, i_plus4, n_ext;
    lift_kind_t                 kind;

    wlr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign n_len = clamp_len(cfg.half_length);

    // Transaction acceptance and row position.
    assign slot_fire     = job_valid_reg && slot_ready;
    assign job_done      = slot_fire && (slot_reg == end_slot_reg);
    assign samples.ready = !job_valid_reg || job_done;
    assign in_fire       = samples.valid && samples.ready;
    assign is_last       = ({1'b0, count_reg} + 12'd1) >= {1'b0, n_len};
    assign has_job       = (count_reg >= HALF_W'(2)) || is_last;

    always_comb
    begin
        count_next = count_reg;
        if (in_fire)
            count_next = is_last ? '0 : count_reg + HALF_W'(1);
    end

    // Window cells.
    assign even_chain[0] = samples.even_sample;
    assign odd_chain[0]  = samples.odd_sample;

    for (genvar k = 0; k < EVEN_TAPS; k++)
    begin : g_even
        wlr_sample_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (in_fire),
            .sample_in  (even_chain[k]),
            .sample_out (even_chain[k+1])
        );
    end

    for (genvar k = 0; k < ODD_TAPS; k++)
    begin : g_odd
        wlr_sample_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (in_fire),
            .sample_in  (odd_chain[k]),
            .sample_out (odd_chain[k+1])
        );
    end

    // Issue control: walk the pending pairs one per cycle while the core takes them.
    always_comb
    begin
        job_valid_next = job_valid_reg;
        slot_next      = slot_reg;
        end_slot_next  = end_slot_reg;
        job_last_next  = job_last_reg;
        if (job_done)
            job_valid_next = 1'b0;
        else if (slot_fire)
            slot_next = slot_reg + 2'd1;
        if (in_fire && has_job)
        begin
            job_valid_next = 1'b1;
            slot_next      = (count_reg >= HALF_W'(2)) ? SLOT_LOW : SLOT_MID;
            end_slot_next  = is_last ? SLOT_HIGH : SLOT_LOW;
            job_last_next  = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            job_valid_reg <= 1'b0;
            slot_reg      <= SLOT_LOW;
            end_slot_reg  <= SLOT_LOW;
            job_last_reg  <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            job_valid_reg <= job_valid_next;
            slot_reg      <= slot_next;
            end_slot_reg  <= end_slot_next;
            job_last_reg  <= job_last_next;
        end
    end

    // Snapshot of the window as seen by the accepted pair.
    always_ff @(posedge clk)
    begin
        if (in_fire && has_job)
        begin
            job_j_reg       <= count_reg;
            job_even_reg[0] <= even_chain[3];
            job_even_reg[1] <= even_chain[2];
            job_even_reg[2] <= even_chain[1];
            job_even_reg[3] <= even_chain[0];
            job_odd_reg[0]  <= odd_chain[2];
            job_odd_reg[1]  <= odd_chain[1];
            job_odd_reg[2]  <= odd_chain[0];
        end
    end

    // Neighbors of the current pair within the snapshot.
    always_comb
    begin
        case (slot_reg)
            SLOT_MID:
            begin
                cur = job_even_reg[2];
                em1 = job_even_reg[1];
                ep1 = job_even_reg[3];
                ep2 = job_even_reg[0];
                odd = job_odd_reg[1];
            end
            SLOT_HIGH:
            begin
                cur = job_even_reg[3];
                em1 = job_even_reg[2];
                ep1 = job_even_reg[0];
                ep2 = job_even_reg[1];
                odd = job_odd_reg[2];
            end
            default:
            begin
                cur = job_even_reg[1];
                em1 = job_even_reg[0];
                ep1 = job_even_reg[2];
                ep2 = job_even_reg[3];
                odd = job_odd_reg[0];
            end
        endcase
    end

    // Edge replication at both ends of the row.
    always_comb
    begin
        i_pos   = job_j_reg + {{(HALF_W-2){1'b0}}, slot_reg} - HALF_W'(2);
        i_plus2 = {1'b0, i_pos} + 12'd2;
        i_plus4 = {1'b0, i_pos} + 12'd4;
        n_ext   = {1'b0, n_len};
        kind    = lift_kind_of(cfg.wavelet_mode, n_len);

        nxt = (i_plus2 < n_ext) ? ep1 : cur;
        il1 = (i_pos == '0) ? cur : em1;
        ip1 = (i_plus2 > n_ext) ? cur : ep1;
        ip2 = (i_plus4 > n_ext) ? ip1 : ep2;

        slot.kind     = kind;
        slot.index    = i_pos[INDEX_W-1:0];
        slot.cur      = cur;
        slot.odd      = odd;
        slot.sum_a    = 17'(cur) + 17'((kind == LIFT_HAAR) ? odd : nxt) + 17'sd1;
        slot.s9       = 17'(cur) + 17'(ip1);
        slot.s1       = 17'(il1) + 17'(ip2);
        slot.i_zero   = (i_pos == '0);
        slot.run_last = (slot_reg == end_slot_reg);
        slot.row_done = job_last_reg && (slot_reg == end_slot_reg);
    end

    wlr_lift_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .slot_valid (job_valid_reg),
        .slot       (slot),
        .slot_ready (slot_ready),
        .coefs      (coefs)
    );

`ifndef NO_ASSERTIONS
    // No new transaction while the issue register still owes earlier pairs.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && (slot_reg != end_slot_reg) |-> !samples.ready)
        else $error("input accepted while a flush is pending");

    // The pair counter never reaches the largest row length.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < HALF_W'(MAX_HALF_LENGTH))
        else $error("pair counter out of range");

    // A two-pair row starts its flush at the first position.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && has_job && (count_reg < HALF_W'(2)) |=> slot_reg == SLOT_MID)
        else $error("short row flush started at the wrong position");
`endif

endmodule

`default_nettype wire

FILE: test/wlr_lift_checker.sv
`timescale 1ns / 1ps

module wlr_lift_checker
    import wlr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    wlr_pair_if                   pairs,
    wlr_coef_if                   coefs,
    output int                    fail_count,
    output int                    pending
);

    // One coefficient pair as the block should deliver it.
    typedef struct packed {
        logic [INDEX_W-1:0]         index;
        logic signed [SAMPLE_W-1:0] low;
        logic signed [SAMPLE_W-1:0] high;
        logic                       done;
        logic                       last;
    } coef_pair_t;

    coef_pair_t coef_fifo[$];

    // Local copy of the register file.
    logic [1:0]  mode_q;
    logic [10:0] half_q;
    logic [15:0] limit_q;
    logic [19:0] gate_q;

    // Lifting state: sample history, ungated highpass of the previous position,
    // and the number of pairs taken so far in the current row.
    int even_hist[EVEN_TAPS];
    int odd_hist[ODD_TAPS];
    int last_high;
    int pairs_in_row;

    function automatic int wrap16(input int x);
        logic signed [15:0] t;
        t = x[15:0];
        return t;
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_value(input logic [1:0] which);
        logic [APB_DATA_W-1:0] v;
        v = '0;
        case (which)
            REG_MODE:  v = APB_DATA_W'(mode_q);
            REG_HALF:  v = APB_DATA_W'(half_q);
            REG_LIMIT: v = APB_DATA_W'(limit_q);
            REG_GATE:  v = APB_DATA_W'(gate_q);
            default:   v = '0;
        endcase
        return v;
    endfunction

    task automatic report(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s", $time, what);
    endtask

    // Take one sample pair and queue every coefficient pair it makes final.
    task automatic lift_pair(input logic signed [15:0] even_v, input logic signed [15:0] odd_v);
        int e[4];
        int o[3];
        int n, j, first, last_i, i, idx, cur, odd_s;
        int hp, lp, hpg, prv, il1, ip1, ip2, nxt, g;
        bit row_end;
        coef_pair_t c;
        n = half_q;
        if (n < 2)
            n = 2;
        if (n > MAX_HALF_LENGTH)
            n = MAX_HALF_LENGTH;
        j = pairs_in_row;
        // e[k] holds the even sample of pair j-3+k, o[k] the odd sample of pair j-2+k.
        e[0] = even_hist[2];
        e[1] = even_hist[1];
        e[2] = even_hist[0];
        e[3] = even_v;
        o[0] = odd_hist[1];
        o[1] = odd_hist[0];
        o[2] = odd_v;
        row_end = (j + 1 >= n);
        first = (j >= 2) ? j - 2 : 0;
        last_i = row_end ? j : j - 2;

        if (j >= 2 || row_end) begin
            for (i = first; i <= last_i; i++) begin
                idx = (i + 3 - j) & 3;
                cur = e[idx];
                odd_s = o[(i + 2 - j) % 3];

                // Predict step, with edge replication near both ends of the row.
                if (mode_q == MODE_HAAR) begin
                    hp = odd_s - ((cur + odd_s + 1) >>> 1);
                end
                else if (mode_q == MODE_FOUR_TAP && n > 4) begin
                    il1 = (i < 1) ? cur : e[(idx - 1) & 3];
                    ip1 = (i + 2 > n) ? cur : e[(idx + 1) & 3];
                    ip2 = (i + 4 > n) ? ip1 : e[(idx + 2) & 3];
                    hp = odd_s - ((-il1 + 9 * cur + 9 * ip1 - ip2 + 8) >>> 4);
                end
                else begin
                    nxt = (i + 2 < n) ? e[(idx + 1) & 3] : cur;
                    hp = odd_s - ((cur + nxt + 1) >>> 1);
                end
                hp = wrap16(hp);

                // Update step works on the highpass before any gating.
                if (mode_q == MODE_HAAR) begin
                    lp = wrap16((cur + odd_s + 1) >>> 1);
                end
                else begin
                    prv = (i == 0) ? hp : last_high;
                    lp = wrap16(cur + ((hp + prv + 2) >>> 2));
                end
                last_high = hp;

                // Level limit, then the dead zone in sixteenths.
                hpg = hp;
                if (limit_q != 0 && 2 * n > limit_q)
                    hpg = 0;
                g = gate_q;
                if (hpg * 16 > -g && hpg * 16 < g)
                    hpg = 0;

                c.index = i[INDEX_W-1:0];
                c.low = lp[15:0];
                c.high = hpg[15:0];
                c.done = row_end && (i == last_i);
                c.last = (i == last_i);
                coef_fifo.push_back(c);
            end
        end

        even_hist[2] = even_hist[1];
        even_hist[1] = even_hist[0];
        even_hist[0] = e[3];
        odd_hist[1] = odd_hist[0];
        odd_hist[0] = o[2];
        pairs_in_row = row_end ? 0 : ((j + 1) & 'h7FF);
    endtask

    // Watch all ports at the rising edge: inputs first, then results, then registers.
    always @(posedge clk or negedge rst_n) begin
        coef_pair_t want;
        if (!rst_n) begin
            coef_fifo.delete();
            mode_q = MODE_CDF53;
            half_q = 11'd2;
            limit_q = '0;
            gate_q = '0;
            even_hist = '{default: 0};
            odd_hist = '{default: 0};
            last_high = 0;
            pairs_in_row = 0;
            pending = 0;
        end
        else begin
            if (pairs.valid && pairs.ready)
                lift_pair(pairs.even_sample, pairs.odd_sample);

            if (coefs.valid && coefs.ready) begin
                if (coef_fifo.size() == 0) begin
                    report($sformatf("unexpected coefficient transaction, index %0d",
                                     coefs.coefficient_index));
                end
                else begin
                    want = coef_fifo.pop_front();
                    if (coefs.coefficient_index !== want.index || coefs.lowpass !== want.low
                        || coefs.highpass !== want.high || coefs.row_done !== want.done
                        || coefs.run_last !== want.last)
                        report($sformatf({"coefficient mismatch: index %0d/%0d low %0d/%0d ",
                                          "high %0d/%0d row_done %0b/%0b run_last %0b/%0b ",
                                          "(expected/actual)"},
                                         want.index, coefs.coefficient_index,
                                         want.low, coefs.lowpass, want.high, coefs.highpass,
                                         want.done, coefs.row_done, want.last, coefs.run_last));
                end
            end

            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[APB_ADDR_W-1:2])
                        REG_MODE:  mode_q = pwdata[1:0];
                        REG_HALF:  half_q = pwdata[10:0];
                        REG_LIMIT: limit_q = pwdata[15:0];
                        REG_GATE:  gate_q = pwdata[19:0];
                        default:   ;
                    endcase
                end
                else if (prdata !== reg_value(paddr[APB_ADDR_W-1:2])) begin
                    report($sformatf("register read mismatch at %0h: expected %0h, got %0h",
                                     paddr, reg_value(paddr[APB_ADDR_W-1:2]), prdata));
                end
            end

            pending = coef_fifo.size();
        end
    end

endmodule

FILE: test/wavelet_lift_row_gate_tb.sv
`timescale 1ns / 1ps

module wavelet_lift_row_gate_tb;
    import wlr_pkg::*;

    // Mode code with no filter of its own; the block treats it as 5/3.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_PAIRS   = 245;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 12;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    wlr_pair_if pair_bus ();
    wlr_coef_if coef_bus ();

    int fail_count;
    int pending;
    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold_request;

    logic [1:0] mode_codes [4] = '{MODE_HAAR, MODE_CDF53, MODE_FOUR_TAP, MODE_SPARE};

    wavelet_lift_row_gate DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (pair_bus),
        .coefs   (coef_bus)
    );

    wlr_lift_checker lift_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .pairs      (pair_bus),
        .coefs      (coef_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Half of the draws are idle when idling is enabled.
    function automatic int draw_wait(input bit enabled);
        if (!enabled || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 14);
    endfunction

    function automatic logic [15:0] draw_sample();
        logic [15:0] corners [4];
        int v;
        corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        v = $urandom_range(0, 127) - 64;
        case ($urandom_range(0, 3))
            0:       return corners[$urandom_range(0, 3)];
            1:       return v[15:0];
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] which, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {which, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic read_regs();
        logic [1:0] which;
        for (int k = 0; k < 4; k++) begin
            which = k[1:0];
            @(negedge clk);
            psel = 1'b1;
            penable = 1'b0;
            pwrite = 1'b0;
            paddr = {which, 2'b00};
            @(negedge clk);
            penable = 1'b1;
            @(negedge clk);
            psel = 1'b0;
            penable = 1'b0;
        end
    endtask

    // Stop offering pairs and wait until every coefficient transaction has arrived,
    // then give the pipeline time to finish work that produces no result.
    task automatic settle();
        @(negedge clk);
        pair_bus.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic [1:0] mode, input int half, input int limit,
                             input int gate);
        settle();
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_HALF, 32'(half));
        write_reg(REG_LIMIT, 32'(limit));
        write_reg(REG_GATE, 32'(gate));
    endtask

    // Offer one pair; valid stays high on return so back-to-back pairs need no gap.
    task automatic send_pair(input logic [15:0] even_v, input logic [15:0] odd_v);
        int gap;
        gap = draw_wait(tx_idle_on);
        @(negedge clk);
        if (gap > 0) begin
            pair_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pair_bus.valid = 1'b1;
        pair_bus.even_sample = even_v;
        pair_bus.odd_sample = odd_v;
        do @(posedge clk); while (!pair_bus.ready);
    endtask

    // Coefficient receiver: a random stall before each transaction, plus one long
    // hold-off whenever the stimulus asks for it.
    initial
    begin
        int stall;
        coef_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_request) begin
                coef_bus.ready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_request = 1'b0;
            end
            stall = draw_wait(rx_idle_on);
            if (stall > 0) begin
                coef_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            coef_bus.ready = 1'b1;
            do @(posedge clk); while (!coef_bus.valid);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int sent;
        int phase;
        int n;
        int items;
        int half;
        int limit;
        int gate;
        logic [1:0] mode;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pair_bus.valid = 1'b0;
        pair_bus.even_sample = '0;
        pair_bus.odd_sample = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        rx_hold_request = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Reset values of the registers.
        read_regs();

        // Haar on a three-pair row of full-scale samples.
        configure(MODE_HAAR, 3, 0, 0);
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h8000);

        // 5/3 on the shortest row: the second pair flushes both positions in one transaction.
        configure(MODE_CDF53, 2, 0, 0);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h7FFF, 16'h8000);

        // Four-tap with edges on both sides.
        configure(MODE_FOUR_TAP, 6, 0, 0);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'hFFFF, 16'h0000);

        // Four-tap falls back to 5/3 on a short row; the widest gate clears all highpass.
        configure(MODE_FOUR_TAP, 4, 65535, 1048575);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h1234, 16'hEDCB);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h0001, 16'hFFFE);

        // Spare mode code, half length below range, level limit just exceeded, then just met.
        configure(MODE_SPARE, 1, 3, 0);
        send_pair(16'h4000, 16'hC000);
        send_pair(16'hC000, 16'h4000);
        configure(MODE_SPARE, 0, 4, 0);
        send_pair(16'h4000, 16'hC000);
        send_pair(16'hC000, 16'h4000);

        // Half length above range, then shortened mid-row so the count is past the end.
        configure(MODE_CDF53, 2047, 0, 80);
        send_pair(16'h0003, 16'h0008);
        send_pair(16'hFFFC, 16'h0002);
        send_pair(16'h0005, 16'hFFF6);
        send_pair(16'h0000, 16'h0004);
        configure(MODE_FOUR_TAP, 3, 0, 80);
        send_pair(16'h0002, 16'hFFF9);
        settle();
        read_regs();

        // Random phases: a fresh setting each, mostly whole rows of random content.
        sent = 0;
        phase = 0;
        while (sent < RANDOM_PAIRS) begin
            phase++;
            mode = mode_codes[$urandom_range(0, 3)];
            case ($urandom_range(0, 19))
                0:       half = $urandom_range(0, 1);
                1:       half = $urandom_range(MAX_HALF_LENGTH + 1, 2047);
                2:       half = $urandom_range(13, 40);
                3:       half = MAX_HALF_LENGTH;
                default: half = $urandom_range(2, 12);
            endcase
            n = (half < 2) ? 2 : ((half > MAX_HALF_LENGTH) ? MAX_HALF_LENGTH : half);
            case ($urandom_range(0, 9))
                0:       limit = 65535;
                1, 2, 3: limit = $urandom_range(1, 4 * n);
                default: limit = 0;
            endcase
            case ($urandom_range(0, 9))
                0:       gate = 1048575;
                1, 2, 3: gate = $urandom_range(1, 2000);
                default: gate = 0;
            endcase
            configure(mode, half, limit, gate);
            if ($urandom_range(0, 3) == 0)
                read_regs();

            // Long rows are only started here; a later setting cuts them short.
            if (n > 40) begin
                items = $urandom_range(3, 20);
            end
            else begin
                items = n * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    items = $urandom_range(1, items);
            end
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on = ($urandom_range(0, 2) != 0);

            // Back pressure: the receiver holds off while pairs keep coming.
            if (phase % 8 == 2) begin
                tx_idle_on = 1'b0;
                rx_hold_request = 1'b1;
                items = items + 30;
            end

            for (int k = 0; k < items; k++) begin
                // Now and then the sender waits for every result before going on.
                if (phase % 5 == 4 && k == items / 2)
                    settle();
                send_pair(draw_sample(), draw_sample());
                sent++;
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
